>>> rtl/core/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared definitions for the palindromic prime test
// Widths, divider sizing, constants and the command and status structs that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

  // Width of the number under test.
  localparam int VALUE_W = 17;
  // Divisor width: the largest divisor reached is 363, whose square exceeds any 17-bit value.
  localparam int DIV_W   = 9;
  // Width of the divisor square.
  localparam int DSQ_W   = 18;
  // Width of the reversed number: up to six digits of reversal.
  localparam int REV_W   = 20;

  // Remainder unit: restoring steps per cycle and cycles per divisor.
  localparam int DIV_STEPS  = 6;
  localparam int DIV_CHUNKS = 3;
  localparam int PAD_W      = DIV_STEPS * DIV_CHUNKS;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  // Division by ten through a reciprocal; exact for every 17-bit value.
  localparam int RECIP_W     = 16;
  localparam int RECIP_10    = 52429;
  localparam int RECIP_SHIFT = 19;

  // Default number of decimal digits in the palindrome range.
  localparam int MAX_DIGITS_DEF = 5;

  // Ten to the power n, evaluated at elaboration.
  function automatic logic [31:0] pow10(input int n);
    logic [31:0] p;
    p = 32'd1;
    for (int k = 0; k < n; k++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new number and restart both tests
    logic step;     // run one chunk of the remainder calculation
    logic first;    // this chunk is the first for the current divisor
    logic advance;  // move on to the next divisor
  } ppt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two; // number is zero or one
    logic sq_over;   // divisor squared exceeds the number
    logic rem_zero;  // remainder out of the current chunk is zero
    logic pal_done;  // palindrome test finished
    logic pal;       // palindrome verdict, valid with pal_done
  } ppt_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp: datapath of the palindromic prime test
// Holds the number, the trial divisor and its square, a chunked restoring
// remainder unit and a one-digit-per-cycle decimal reversal unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_dp #(
  parameter int MAX_DIGITS = ppt_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [ppt_pkg::VALUE_W-1:0]  value,
  input  wire ppt_pkg::ppt_cmd_t            cmd,
  output ppt_pkg::ppt_sts_t                 sts
);

  localparam logic [31:0] LIMIT = ppt_pkg::pow10(MAX_DIGITS);
  localparam int PROD_W = ppt_pkg::VALUE_W + ppt_pkg::RECIP_W;

  logic [ppt_pkg::VALUE_W-1:0] v_r;
  logic [ppt_pkg::DIV_W-1:0]   d_r,   d_nxt;
  logic [ppt_pkg::DSQ_W-1:0]   dsq_r, dsq_nxt;
  logic [ppt_pkg::PAD_W-1:0]   sh_r,  sh_nxt;
  logic [ppt_pkg::DIV_W-1:0]   rem_r, rem_nxt;

  logic [ppt_pkg::VALUE_W-1:0] rest_r, rest_nxt;
  logic [ppt_pkg::REV_W-1:0]   rev_r,  rev_nxt;
  logic                        in_range_r;
  logic                        pal_done_r, pal_done_nxt;
  logic                        pal_r, pal_nxt;

  logic [ppt_pkg::PAD_W-1:0]   src;
  logic [ppt_pkg::DIV_W:0]     t;
  logic [PROD_W-1:0]           prod;
  logic [ppt_pkg::VALUE_W-1:0] quot;
  logic [ppt_pkg::VALUE_W-1:0] quot10;
  logic [3:0]                  digit;

  // Remainder unit: a few restoring steps per cycle, most significant bit first.
  always_comb begin
    src     = cmd.first ? ppt_pkg::PAD_W'(v_r) : sh_r;
    rem_nxt = cmd.first ? '0 : rem_r;
    t       = '0;
    for (int i = 0; i < ppt_pkg::DIV_STEPS; i++) begin
      t = {rem_nxt, src[ppt_pkg::PAD_W-1-i]};
      if (t >= {1'b0, d_r}) begin
        t = t - {1'b0, d_r};
      end
      rem_nxt = t[ppt_pkg::DIV_W-1:0];
    end
    sh_nxt = src << ppt_pkg::DIV_STEPS;
  end

  // Next divisor: three follows two, then odd divisors only.
  always_comb begin
    if (d_r == ppt_pkg::DIV_W'(2)) begin
      d_nxt   = ppt_pkg::DIV_W'(3);
      dsq_nxt = ppt_pkg::DSQ_W'(9);
    end else begin
      d_nxt   = d_r + ppt_pkg::DIV_W'(2);
      dsq_nxt = dsq_r + (ppt_pkg::DSQ_W'(d_r) << 2) + ppt_pkg::DSQ_W'(4);
    end
  end

  // Decimal reversal: peel the lowest digit by a reciprocal multiply.
  always_comb begin
    prod    = rest_r * ppt_pkg::RECIP_W'(ppt_pkg::RECIP_10);
    quot    = ppt_pkg::VALUE_W'(prod >> ppt_pkg::RECIP_SHIFT);
    quot10  = (quot << 3) + (quot << 1);
    digit   = 4'(rest_r - quot10);
    rev_nxt = (rev_r << 3) + (rev_r << 1) + ppt_pkg::REV_W'(digit);
    rest_nxt     = quot;
    pal_done_nxt = pal_done_r;
    pal_nxt      = pal_r;
    if (!pal_done_r && rest_r == '0) begin
      pal_done_nxt = 1'b1;
      pal_nxt      = in_range_r && (rev_r == ppt_pkg::REV_W'(v_r));
    end
  end

  // Divisor, square and remainder registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r   <= ppt_pkg::DIV_W'(2);
      dsq_r <= ppt_pkg::DSQ_W'(4);
    end else if (cmd.load) begin
      d_r   <= ppt_pkg::DIV_W'(2);
      dsq_r <= ppt_pkg::DSQ_W'(4);
    end else if (cmd.advance) begin
      d_r   <= d_nxt;
      dsq_r <= dsq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r        <= value;
      in_range_r <= (32'(value) < LIMIT);
    end
    if (cmd.step) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  // Reversal registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_done_r <= 1'b1;
      pal_r      <= 1'b0;
    end else if (cmd.load) begin
      pal_done_r <= 1'b0;
      pal_r      <= 1'b0;
    end else begin
      pal_done_r <= pal_done_nxt;
      pal_r      <= pal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r <= value;
      rev_r  <= '0;
    end else if (!pal_done_r) begin
      rest_r <= rest_nxt;
      rev_r  <= rev_nxt;
    end
  end

  // Status towards the controller.
  assign sts.below_two = (v_r[ppt_pkg::VALUE_W-1:1] == '0);
  assign sts.sq_over   = (dsq_r > ppt_pkg::DSQ_W'(v_r));
  assign sts.rem_zero  = (rem_nxt == '0);
  assign sts.pal_done  = pal_done_r;
  assign sts.pal       = pal_r;

  // The square register tracks the divisor exactly.
  a_dsq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    dsq_r == ppt_pkg::DSQ_W'(d_r) * ppt_pkg::DSQ_W'(d_r))
    else $error("divisor square out of step with divisor");

  // Once finished, the palindrome verdict holds until the next number.
  a_pal_holds: assert property (@(posedge clk) disable iff (!rst_n)
    pal_done_r && !cmd.load |=> pal_done_r && $stable(pal_r))
    else $error("palindrome verdict changed without a new number");

  // A load always restarts the reversal.
  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !pal_done_r)
    else $error("palindrome test not restarted by a load");

endmodule

`default_nettype wire

>>> rtl/core/ppt_ctrl.sv
// ----------------------------------------------------------------------------
// ppt_ctrl: controller of the palindromic prime test
// Sequences the trial divisors through the datapath, decides primality and
// drives the result strobe once the palindrome test has finished.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output ppt_pkg::ppt_cmd_t       cmd,
  input  wire ppt_pkg::ppt_sts_t  sts,
  output logic                    out_valid,
  output logic                    out_is_prime,
  output logic                    out_is_palindrome,
  output logic                    out_is_palindromic_prime
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WAIT
  } state_t;

  localparam logic [ppt_pkg::CHUNK_W-1:0] LAST_CHUNK = ppt_pkg::CHUNK_W'(ppt_pkg::DIV_CHUNKS - 1);

  state_t                       state_r, state_nxt;
  logic [ppt_pkg::CHUNK_W-1:0]  chunk_r, chunk_nxt;
  logic                         prime_r, prime_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_prime_r, out_prime_nxt;
  logic                         out_pal_r,   out_pal_nxt;
  logic                         out_pp_r,    out_pp_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state, commands and result.
  always_comb begin
    state_nxt     = state_r;
    chunk_nxt     = chunk_r;
    prime_nxt     = prime_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    out_pal_nxt   = out_pal_r;
    out_pp_nxt    = out_pp_r;
    cmd           = '0;
    cmd.first     = (chunk_r == '0);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          chunk_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.below_two) begin
          prime_nxt = 1'b0;
          state_nxt = S_WAIT;
        end else if (chunk_r == '0 && sts.sq_over) begin
          prime_nxt = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.step = 1'b1;
          if (chunk_r == LAST_CHUNK) begin
            chunk_nxt = '0;
            if (sts.rem_zero) begin
              prime_nxt = 1'b0;
              state_nxt = S_WAIT;
            end else begin
              cmd.advance = 1'b1;
            end
          end else begin
            chunk_nxt = chunk_r + 1'b1;
          end
        end
      end
      S_WAIT: begin
        if (sts.pal_done) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
          out_pal_nxt   = sts.pal;
          out_pp_nxt    = prime_r && sts.pal;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      prime_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_prime_r <= 1'b0;
      out_pal_r   <= 1'b0;
      out_pp_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      prime_r     <= prime_nxt;
      out_valid_r <= out_valid_nxt;
      out_prime_r <= out_prime_nxt;
      out_pal_r   <= out_pal_nxt;
      out_pp_r    <= out_pp_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_is_prime             = out_prime_r;
  assign out_is_palindrome        = out_pal_r;
  assign out_is_palindromic_prime = out_pp_r;

  // A result beat only follows a finished palindrome test.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_WAIT && sts.pal_done))
    else $error("result beat without a finished test");

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // The chunk counter only runs during division.
  a_chunk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_r != '0 |-> state_r == S_DIV)
    else $error("chunk counter active outside division");

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid_r)
    else $error("accepted beat did not start a test");

endmodule

`default_nettype wire

>>> rtl/core/palindromic_prime_test.sv
// For a number of two or more, trial divisors run 2, then odd ones, until one divides the
// number or its square exceeds it; the remainder unit does six restoring steps a cycle,
// and the result strobe also waits for the digit reversal of the palindrome test to finish.
// One number at a time; a new beat is taken in the cycle the result strobe is shown.
// Synchronous reset clears the controller; the receiver cannot stall, each result shows once.
// ----------------------------------------------------------------------------
// palindromic_prime_test: prime and decimal palindrome test
// Trial division up to the integer square root, and a digit reversal test,
// reporting prime, palindrome and both for each number.
// ----------------------------------------------------------------------------
`default_nettype none

module palindromic_prime_test #(
  parameter int MAX_DIGITS = ppt_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ppt_pkg::VALUE_W-1:0]  in_value,
  output logic                              out_valid,
  output logic                              out_is_prime,
  output logic                              out_is_palindrome,
  output logic                              out_is_palindromic_prime
);

  ppt_pkg::ppt_cmd_t cmd;
  ppt_pkg::ppt_sts_t sts;

  // Controller.
  ppt_ctrl u_ctrl (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .cmd                      (cmd),
    .sts                      (sts),
    .out_valid                (out_valid),
    .out_is_prime             (out_is_prime),
    .out_is_palindrome        (out_is_palindrome),
    .out_is_palindromic_prime (out_is_palindromic_prime)
  );

  // Datapath.
  ppt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .value (in_value),
    .cmd   (cmd),
    .sts   (sts)
  );

endmodule

`default_nettype wire
